>>> sv/bhtc_pkg.sv
// Shared types and constants for the bearer header token check.
// Holds the request and result structs, the verdict codes and the scheme text.
// No dependencies.
package bhtc_pkg;

	localparam int TOKEN_MAX_BYTES = 48;
	localparam int TOKEN_WORDS     = 6;
	localparam int SCHEME_LEN      = 7;
	localparam int CNT_W           = 6;
	localparam int POS_W           = 3;
	localparam int IDX_W           = 3;

	localparam logic [IDX_W-1:0] CFG_IDX_TOKEN_LENGTH = IDX_W'(TOKEN_WORDS);

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	// "bearer ", entry 0 first
	localparam logic [SCHEME_LEN-1:0][7:0] SCHEME_TEXT = {
		8'h20, 8'h72, 8'h65, 8'h72, 8'h61, 8'h65, 8'h62
	};

	typedef enum logic [1:0] {
		VERDICT_MATCH          = 2'd0,
		VERDICT_NO_TOKEN       = 2'd1,
		VERDICT_BAD_SCHEME     = 2'd2,
		VERDICT_TOKEN_MISMATCH = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       last_byte;
	} hdr_t;

	typedef struct packed {
		logic     accepted;
		verdict_t verdict;
	} res_t;

	typedef struct packed {
		logic [TOKEN_MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]                length;
	} token_cfg_t;

endpackage

>>> sv/bearer_header_token_check.sv
// Top level of the bearer header token check.
// Depends on bhtc_pkg, bhtc_cfg and bhtc_scan.
//
// Takes one header byte per cycle with no gaps required. A byte is registered on acceptance
// and scanned in the following cycle; a byte flagged last puts its result in the result
// register as it advances, and the result waits there while new bytes keep flowing.
// Only a flagged byte arriving while an untaken result is held stalls the input. The token
// compare runs at full length with no early exit. Configuration writes are always taken and
// should be issued only while no header is in flight.
module bearer_header_token_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       hdr_valid,
	output logic                       hdr_ready,
	input  bhtc_pkg::hdr_t             hdr,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bhtc_pkg::res_t             res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bhtc_pkg::IDX_W-1:0] cfg_index,
	input  logic [63:0]                cfg_data
);
	import bhtc_pkg::*;

	hdr_t       hdr_s1;
	logic       valid_s1;
	res_t       res_s2;
	logic       valid_s2;
	logic       advance;
	res_t       scan_res;
	token_cfg_t token_cfg;

	assign cfg_ready = 1'b1;

	bhtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.token_cfg (token_cfg)
	);

	assign advance   = valid_s1 && !(hdr_s1.last_byte && valid_s2 && !res_ready);
	assign hdr_ready = !valid_s1 || advance;

	bhtc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.hdr       (hdr_s1),
		.token_cfg (token_cfg),
		.res       (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_valid && hdr_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_valid && hdr_ready) begin
			hdr_s1 <= hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && hdr_s1.last_byte) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hdr_s1.last_byte) begin
			res_s2 <= scan_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

>>> sv/bhtc_cfg.sv
// Configuration registers: six token words and the token length.
// Depends on bhtc_pkg.
module bhtc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [bhtc_pkg::IDX_W-1:0] wr_index,
	input  logic [63:0]               wr_data,
	output bhtc_pkg::token_cfg_t      token_cfg
);
	import bhtc_pkg::*;

	logic [TOKEN_WORDS-1:0][63:0] words_q;
	logic [CNT_W-1:0]             length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q  <= '0;
			length_q <= '0;
		end else if (wr_en) begin
			if (wr_index < CFG_IDX_TOKEN_LENGTH) begin
				words_q[wr_index] <= wr_data;
			end else if (wr_index == CFG_IDX_TOKEN_LENGTH) begin
				length_q <= wr_data[CNT_W-1:0];
			end
		end
	end

	assign token_cfg.bytes  = words_q;
	assign token_cfg.length = length_q;

endmodule

>>> sv/bhtc_scan.sv
// Per-header scan state: scheme prefix check, token compare and verdict.
// Depends on bhtc_pkg.
module bhtc_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  bhtc_pkg::hdr_t       hdr,
	input  bhtc_pkg::token_cfg_t token_cfg,
	output bhtc_pkg::res_t       res
);
	import bhtc_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	logic             fail_q, fail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             differs_q, differs_d;
	logic             ended_q, ended_d;
	logic [CNT_W-1:0] eff_len;
	logic [7:0]       folded;
	logic [7:0]       expected;
	verdict_t         verdict;

	assign eff_len = (token_cfg.length > CNT_W'(TOKEN_MAX_BYTES)) ?
		CNT_W'(TOKEN_MAX_BYTES) : token_cfg.length;

	assign folded = (hdr.header_byte >= CHAR_UPPER_A && hdr.header_byte <= CHAR_UPPER_Z) ?
		hdr.header_byte - CHAR_UPPER_A + CHAR_LOWER_A : hdr.header_byte;

	assign expected = (count_q < CNT_W'(TOKEN_MAX_BYTES)) ? token_cfg.bytes[count_q] : 8'd0;

	always_comb begin
		pos_d     = pos_q;
		fail_d    = fail_q;
		count_d   = count_q;
		differs_d = differs_q;
		ended_d   = ended_q;
		if (!ended_q) begin
			if (hdr.header_byte == 8'd0) begin
				ended_d = 1'b1;
			end else if (pos_q < POS_W'(SCHEME_LEN)) begin
				if (folded != SCHEME_TEXT[pos_q]) begin
					fail_d = 1'b1;
				end
				pos_d = pos_q + 1'b1;
			end else begin
				if (count_q < eff_len && hdr.header_byte != expected) begin
					differs_d = 1'b1;
				end
				if (count_q <= CNT_W'(TOKEN_MAX_BYTES)) begin
					count_d = count_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		priority if (eff_len == '0) begin
			verdict = VERDICT_NO_TOKEN;
		end else if (fail_d || pos_d < POS_W'(SCHEME_LEN)) begin
			verdict = VERDICT_BAD_SCHEME;
		end else if (differs_d || count_d != eff_len) begin
			verdict = VERDICT_TOKEN_MISMATCH;
		end else begin
			verdict = VERDICT_MATCH;
		end
	end

	assign res.verdict  = verdict;
	assign res.accepted = (verdict == VERDICT_MATCH);

	// clear after the flagged byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			fail_q    <= 1'b0;
			count_q   <= '0;
			differs_q <= 1'b0;
			ended_q   <= 1'b0;
		end else if (take) begin
			if (hdr.last_byte) begin
				pos_q     <= '0;
				fail_q    <= 1'b0;
				count_q   <= '0;
				differs_q <= 1'b0;
				ended_q   <= 1'b0;
			end else begin
				pos_q     <= pos_d;
				fail_q    <= fail_d;
				count_q   <= count_d;
				differs_q <= differs_d;
				ended_q   <= ended_d;
			end
		end
	end

endmodule

>>> sv/bhtc_checker.sv
// Port-level checks for the bearer header token check, bound to the top level.
// Depends on bhtc_pkg and bearer_header_token_check.
module bhtc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       hdr_valid,
	input logic                       hdr_ready,
	input bhtc_pkg::hdr_t             hdr,
	input logic                       res_valid,
	input logic                       res_ready,
	input bhtc_pkg::res_t             res
);
	import bhtc_pkg::*;

	a_accept_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.accepted == (res.verdict == VERDICT_MATCH)))
		else $error("accepted flag disagrees with verdict");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(hdr_valid && hdr_ready && hdr.last_byte, 2))
		else $error("result without a flagged request two cycles earlier");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> hdr_ready)
		else $error("input stalled with no result pending");

endmodule

bind bearer_header_token_check bhtc_checker u_bhtc_checker (.*);
